// ----- design/rtdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtdc_pkg
// Shared types, widths and constants of the RTD code to temperature unit.
// ----------------------------------------------------------------------------
package rtdc_pkg;

    // Field and register widths.
    localparam int CODE_W = 15;
    localparam int REF_W  = 13;
    localparam int NOM_W  = 10;
    localparam int CFG_W  = 13;

    // Resistance product and the ratio divider.
    localparam int N_W    = CODE_W + REF_W;      // code * reference_ohms
    localparam int DIVD_W = N_W + 10;            // dividend N*512 + r0 - 1
    localparam int Q_W    = 28;                  // quotient bits, one per cell
    localparam int DREM_W = NOM_W;               // partial remainder
    localparam int DIV_CELLS = Q_W;

    // Discriminant and its square root.
    localparam int PM_W    = 55;                 // q * step product
    localparam int DISC_W  = 62;
    localparam int ROOT_W  = DISC_W / 2;
    localparam int SREM_W  = ROOT_W + 1;
    localparam int SQRT_CELLS = ROOT_W;

    // Callendar-Van Dusen constants in integer form.
    // Quotient at which the ratio clamps (u = -7).
    localparam logic [Q_W-1:0] Q_CLAMP = Q_W'(64'd1 << 27);
    // (a^2 + 4|b|) * 1e16 * 2^24.
    localparam logic [63:0] DISC_BASE = 64'd175848088900 << 24;
    // 4|b| * 1e16 / 2^8.
    localparam logic [26:0] DISC_STEP = 27'd90234375;
    // a * 1e8 * 2^12.
    localparam logic [32:0] A_SCALED = 33'd1600839680;

    // Output scaling: floor(y / 1155) by reciprocal with one correction.
    localparam int OUT_DIV     = 1155;
    localparam int SAT_SPAN    = 32768 * OUT_DIV;
    localparam int YOFF_W      = 27;
    localparam int RECIP_SHIFT = 38;
    localparam logic [27:0] RECIP_M = 28'd237989529;
    localparam int P_W  = YOFF_W + 28;
    localparam int Q0_W = P_W - RECIP_SHIFT;

    localparam int FRACTION_BITS_DEF = 4;

    // Status codes.
    localparam logic [1:0] ST_VALID      = 2'd0;
    localparam logic [1:0] ST_FAULT_BYTE = 2'd1;
    localparam logic [1:0] ST_CODE_FAULT = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_REFERENCE = 1'b0;
    localparam logic CFG_NOMINAL   = 1'b1;

    typedef struct packed {
        logic [7:0] fault_byte;
        logic [7:0] code_high;
        logic [7:0] code_low;
    } t_rtdc_in;

    typedef struct packed {
        logic signed [15:0] temperature_f;
        logic [1:0]         status;
    } t_rtdc_out;

    // Control that travels with each beat from stage to stage.
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } t_ctl;

endpackage
`default_nettype wire

// ----- design/rtdc_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtdc_div_cell
// One restoring division step: takes the next dividend bit, yields one
// quotient bit.
// ----------------------------------------------------------------------------
module rtdc_div_cell
    import rtdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    output logic                   o_ready,
    input  wire logic              i_ready,
    output t_ctl                   o_ctl,
    input  wire logic [NOM_W-1:0]  i_divisor,
    input  wire logic [DREM_W-1:0] i_rem,
    input  wire logic [Q_W-1:0]    i_word,
    input  wire logic              i_clamp,
    output logic [DREM_W-1:0]      o_rem,
    output logic [Q_W-1:0]         o_word,
    output logic                   o_clamp
);

    t_ctl              r_ctl;
    logic [DREM_W-1:0] r_rem;
    logic [Q_W-1:0]    r_word;
    logic              r_clamp;
    logic [DREM_W:0]   w_trial;
    logic [DREM_W:0]   w_diff;
    logic              w_ge;

    // The word shifts dividend bits out at the top and quotient bits in below.
    assign w_trial = {i_rem, i_word[Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign o_ready = !r_ctl.valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_rem   <= w_ge ? w_diff[DREM_W-1:0] : w_trial[DREM_W-1:0];
            r_word  <= {i_word[Q_W-2:0], w_ge};
            r_clamp <= i_clamp;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_word  = r_word;
    assign o_clamp = r_clamp;

endmodule
`default_nettype wire

// ----- design/rtdc_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtdc_sqrt_cell
// One digit-by-digit square root step: takes two radicand bits, yields one
// root bit.
// ----------------------------------------------------------------------------
module rtdc_sqrt_cell
    import rtdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    output logic                   o_ready,
    input  wire logic              i_ready,
    output t_ctl                   o_ctl,
    input  wire logic [SREM_W-1:0] i_rem,
    input  wire logic [ROOT_W-1:0] i_root,
    input  wire logic [DISC_W-1:0] i_rad,
    output logic [SREM_W-1:0]      o_rem,
    output logic [ROOT_W-1:0]      o_root,
    output logic [DISC_W-1:0]      o_rad
);

    t_ctl              r_ctl;
    logic [SREM_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [DISC_W-1:0] r_rad;
    logic [SREM_W+1:0] w_t;
    logic [SREM_W+1:0] w_trial;
    logic [SREM_W+1:0] w_diff;
    logic              w_ge;

    assign w_t     = {i_rem, i_rad[DISC_W-1 -: 2]};
    assign w_trial = (SREM_W + 2)'({i_root, 2'b01});
    assign w_ge    = w_t >= w_trial;
    assign w_diff  = w_t - w_trial;
    assign o_ready = !r_ctl.valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_rem  <= w_ge ? w_diff[SREM_W-1:0] : w_t[SREM_W-1:0];
            r_root <= {i_root[ROOT_W-2:0], w_ge};
            r_rad  <= {i_rad[DISC_W-3:0], 2'b00};
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule
`default_nettype wire

// ----- design/rtd_code_to_temperature_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_code_to_temperature_unit
// Converts one RTD converter reading into a Fahrenheit temperature by the
// Callendar-Van Dusen quadratic, with fault reporting.
//
//   Channel  Direction  Handshake                Beat
//   in       input      i_in_valid / o_in_stall  fault byte, code high, code low
//   out      output     o_out_valid / i_out_stall temperature_f, status
//   cfg      input      i_cfg_we                 register index and data
//
// One reading enters per cycle while the input is not stalled; each beat passes
// two front stages, 28 division cells (one quotient bit each), two stages
// for the discriminant, 31 square root cells (one root bit each) and three
// output stages. Reset is synchronous: it empties the pipeline and loads the
// registers with 400 ohms reference and 100 ohms nominal. Each stage moves on
// when the next one is empty or moving, so a stall at the output fills the
// bubbles behind it before the input stalls.
// ----------------------------------------------------------------------------
module rtd_code_to_temperature_unit
    import rtdc_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_rtdc_in         i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_rtdc_out             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    // Width of the scaled Fahrenheit numerator and its value over 2048.
    localparam int XW  = 37 + FRACTION_BITS;
    localparam int YW  = XW - 11;
    localparam int YEW = YW + 2;
    // 32 degrees plus half of the rounding step, over the common denominator.
    localparam longint X_BIAS_L = (longint'(75694080) << FRACTION_BITS) + 1182720;
    localparam logic signed [XW-1:0] X_BIAS = XW'(X_BIAS_L);

    // Configuration registers.
    logic [REF_W-1:0] r_reference;
    logic [NOM_W-1:0] r_nominal;
    logic [NOM_W-1:0] w_r0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference <= REF_W'(400);
            r_nominal   <= NOM_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REFERENCE: r_reference <= i_cfg_data[REF_W-1:0];
                CFG_NOMINAL:   r_nominal   <= i_cfg_data[NOM_W-1:0];
                default:       r_reference <= r_reference;
            endcase
        end
    end

    // A nominal resistance of zero is taken as one ohm.
    assign w_r0 = (r_nominal == '0) ? NOM_W'(1) : r_nominal;

    // Ready chain, from the output back to the input.
    t_ctl r_s0_ctl, r_s1_ctl, r_pm_ctl, r_pd_ctl, r_o1_ctl, r_o2_ctl, r_out_ctl;
    logic w_s0_rdy, w_s1_rdy, w_pm_rdy, w_pd_rdy, w_o1_rdy, w_o2_rdy, w_out_rdy;

    t_ctl              dv_ctl  [0:DIV_CELLS];
    logic              dv_rdy  [0:DIV_CELLS];
    logic [DREM_W-1:0] dv_rem  [0:DIV_CELLS];
    logic [Q_W-1:0]    dv_word [0:DIV_CELLS];
    logic              dv_clamp[0:DIV_CELLS];

    t_ctl              sq_ctl [0:SQRT_CELLS];
    logic              sq_rdy [0:SQRT_CELLS];
    logic [SREM_W-1:0] sq_rem [0:SQRT_CELLS];
    logic [ROOT_W-1:0] sq_root[0:SQRT_CELLS];
    logic [DISC_W-1:0] sq_rad [0:SQRT_CELLS];

    assign w_out_rdy = !r_out_ctl.valid || !i_out_stall;
    assign w_o2_rdy  = !r_o2_ctl.valid || w_out_rdy;
    assign w_o1_rdy  = !r_o1_ctl.valid || w_o2_rdy;
    assign sq_rdy[SQRT_CELLS] = w_o1_rdy;
    assign w_pd_rdy  = !r_pd_ctl.valid || sq_rdy[0];
    assign w_pm_rdy  = !r_pm_ctl.valid || w_pd_rdy;
    assign dv_rdy[DIV_CELLS] = w_pm_rdy;
    assign w_s1_rdy  = !r_s1_ctl.valid || dv_rdy[0];
    assign w_s0_rdy  = !r_s0_ctl.valid || w_s1_rdy;
    assign o_in_stall = !w_s0_rdy;

    // Stage 0: fault decode and resistance product code * reference_ohms.
    logic [CODE_W-1:0] w_code;
    logic [1:0]        w_status;
    logic [N_W-1:0]    r_n;

    assign w_code = {i_in.code_high, i_in.code_low[7:1]};

    always_comb begin
        if (i_in.fault_byte != 8'd0) begin
            w_status = ST_FAULT_BYTE;
        end else if (i_in.code_low[0]) begin
            w_status = ST_CODE_FAULT;
        end else begin
            w_status = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else if (w_s0_rdy) begin
            r_s0_ctl <= '{valid: i_in_valid, status: w_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_rdy && i_in_valid) begin
            r_n <= N_W'(w_code) * N_W'(r_reference);
        end
    end

    // Stage 1: the ratio needs q = ceil(N * 512 / r0). Beyond the curve
    // (N above r0 * 2^18) the quotient is clamped and the divider idles on zero.
    logic              w_clamp;
    logic [DIVD_W-1:0] w_dividend;
    logic [DIVD_W-1:0] r_dividend;
    logic              r_clamp;

    assign w_clamp    = r_n > {w_r0, 18'd0};
    assign w_dividend = w_clamp ? '0
                      : DIVD_W'({r_n, 9'd0}) + DIVD_W'(w_r0) - DIVD_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (w_s1_rdy) begin
            r_s1_ctl <= r_s0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_rdy && r_s0_ctl.valid) begin
            r_dividend <= w_dividend;
            r_clamp    <= w_clamp;
        end
    end

    // Division cells, one quotient bit each.
    assign dv_ctl[0]   = r_s1_ctl;
    assign dv_rem[0]   = r_dividend[DIVD_W-1:Q_W];
    assign dv_word[0]  = r_dividend[Q_W-1:0];
    assign dv_clamp[0] = r_clamp;

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        rtdc_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (dv_ctl[k]),
            .o_ready   (dv_rdy[k]),
            .i_ready   (dv_rdy[k+1]),
            .o_ctl     (dv_ctl[k+1]),
            .i_divisor (w_r0),
            .i_rem     (dv_rem[k]),
            .i_word    (dv_word[k]),
            .i_clamp   (dv_clamp[k]),
            .o_rem     (dv_rem[k+1]),
            .o_word    (dv_word[k+1]),
            .o_clamp   (dv_clamp[k+1])
        );
    end

    // Discriminant, first half: q times the scaled 4|b| step.
    logic [Q_W-1:0]  w_q;
    logic [PM_W-1:0] r_pm;

    assign w_q = dv_clamp[DIV_CELLS] ? Q_CLAMP : dv_word[DIV_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm_ctl <= '0;
        end else if (w_pm_rdy) begin
            r_pm_ctl <= dv_ctl[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pm_rdy && dv_ctl[DIV_CELLS].valid) begin
            r_pm <= PM_W'(w_q) * PM_W'(DISC_STEP);
        end
    end

    // Discriminant, second half: subtract from the base, floor at zero.
    logic signed [63:0] w_diff;
    logic [DISC_W-1:0]  r_disc;

    assign w_diff = $signed(DISC_BASE) - $signed(64'({r_pm, 8'd0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd_ctl <= '0;
        end else if (w_pd_rdy) begin
            r_pd_ctl <= r_pm_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pd_rdy && r_pm_ctl.valid) begin
            r_disc <= w_diff[63] ? '0 : w_diff[DISC_W-1:0];
        end
    end

    // Square root cells, one root bit each.
    assign sq_ctl[0]  = r_pd_ctl;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = r_disc;

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        rtdc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (sq_ctl[k]),
            .o_ready (sq_rdy[k]),
            .i_ready (sq_rdy[k+1]),
            .o_ctl   (sq_ctl[k+1]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_rad   (sq_rad[k]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_rad   (sq_rad[k+1])
        );
    end

    // Output stage 1: n = a' - s, Fahrenheit numerator over 2048, and the
    // saturation test. The value is then offset to be non-negative.
    logic signed [32:0]     w_n;
    logic signed [XW-1:0]   w_n_ext;
    logic signed [XW-1:0]   w_x;
    logic signed [YEW-1:0]  w_y;
    logic signed [YEW-1:0]  w_yoff;
    logic                   w_hi;
    logic                   w_lo;
    logic [YOFF_W-1:0]      r_y1;
    logic                   r_hi1;
    logic                   r_lo1;

    assign w_n     = $signed(A_SCALED) - $signed(33'(sq_root[SQRT_CELLS]));
    assign w_n_ext = XW'(w_n);
    assign w_x     = (((w_n_ext <<< 3) + w_n_ext) <<< FRACTION_BITS) + X_BIAS;
    // Readings below zero Fahrenheit give a negative numerator; keep its sign.
    assign w_y     = YEW'($signed(w_x[XW-1:11]));
    assign w_hi    = w_y >= YEW'(SAT_SPAN);
    assign w_lo    = w_y < YEW'(-SAT_SPAN);
    assign w_yoff  = w_y + YEW'(SAT_SPAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_ctl <= '0;
        end else if (w_o1_rdy) begin
            r_o1_ctl <= sq_ctl[SQRT_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o1_rdy && sq_ctl[SQRT_CELLS].valid) begin
            r_y1  <= w_yoff[YOFF_W-1:0];
            r_hi1 <= w_hi;
            r_lo1 <= w_lo;
        end
    end

    // Output stage 2: reciprocal product for the divide by 1155.
    logic [P_W-1:0]    r_p;
    logic [YOFF_W-1:0] r_y2;
    logic              r_hi2;
    logic              r_lo2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o2_ctl <= '0;
        end else if (w_o2_rdy) begin
            r_o2_ctl <= r_o1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o2_rdy && r_o1_ctl.valid) begin
            r_p   <= P_W'(r_y1) * P_W'(RECIP_M);
            r_y2  <= r_y1;
            r_hi2 <= r_hi1;
            r_lo2 <= r_lo1;
        end
    end

    // Output stage 3: the estimate is at most one low; correct it, remove the
    // offset, saturate and blank on fault.
    logic [Q0_W-1:0]    w_q0;
    logic [YOFF_W:0]    w_rem;
    logic [Q0_W-1:0]    w_qt;
    logic signed [15:0] w_temp;
    t_rtdc_out          r_out;

    assign w_q0  = r_p[P_W-1:RECIP_SHIFT];
    assign w_rem = (YOFF_W + 1)'(r_y2) - (YOFF_W + 1)'(w_q0) * (YOFF_W + 1)'(OUT_DIV);
    assign w_qt  = w_q0 + Q0_W'(w_rem >= (YOFF_W + 1)'(OUT_DIV));

    always_comb begin
        if (r_o2_ctl.status != ST_VALID) begin
            w_temp = '0;
        end else if (r_hi2) begin
            w_temp = 16'sh7FFF;
        end else if (r_lo2) begin
            w_temp = -16'sh8000;
        end else begin
            w_temp = {~w_qt[15], w_qt[14:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl <= '0;
        end else if (w_out_rdy) begin
            r_out_ctl <= r_o2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && r_o2_ctl.valid) begin
            r_out.temperature_f <= w_temp;
            r_out.status        <= r_o2_ctl.status;
        end
    end

    assign o_out_valid = r_out_ctl.valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ----- design/rtdc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtdc_checker
// Port-level checks of the RTD code to temperature unit.
// ----------------------------------------------------------------------------
module rtdc_checker
    import rtdc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_rtdc_out o_out
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown right after reset");

    // A faulted reading always carries temperature zero.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_VALID |-> o_out.temperature_f == 16'sd0)
        else $error("fault beat with nonzero temperature");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == ST_VALID || o_out.status == ST_FAULT_BYTE
                         || o_out.status == ST_CODE_FAULT))
        else $error("undefined status code");

    // The input stalls only when the output holds a beat that is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output can drain");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

endmodule

bind rtd_code_to_temperature_unit rtdc_checker u_rtdc_checker (.*);
`default_nettype wire
